>>> src/tac_pkg.sv
// Shared constants and codes for the touch affine calibration block.
package tac_pkg;

  localparam int OUT_W      = 12;
  localparam int RAW_W      = 12;
  localparam int FUNC_W     = 1;
  localparam int SIZE_W     = 13;
  localparam int ROT_W      = 2;
  localparam int REF_W      = 48;
  localparam int COEF_W     = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_IDX_W  = 3;

  localparam logic [FUNC_W-1:0] FUNC_MAP   = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_SOLVE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TOP_LEFT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_RIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_LEFT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_ROT = 3'd5;

  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd320;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd240;
  localparam logic [ROT_W-1:0]  ROT_RESET    = ROT_270;

endpackage

>>> src/tac_if.sv
// Valid/ready channel interfaces for touch items and mapped results.
interface tac_in_if;
  import tac_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [RAW_W-1:0]  raw_x;
  logic [RAW_W-1:0]  raw_y;
  modport source (output valid, func, raw_x, raw_y, input ready);
  modport sink   (input valid, func, raw_x, raw_y, output ready);
endinterface

interface tac_out_if;
  import tac_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] screen_x;
  logic [OUT_W-1:0] screen_y;
  logic             calibrated;
  modport source (output valid, screen_x, screen_y, calibrated, input ready);
  modport sink   (input valid, screen_x, screen_y, calibrated, output ready);
endinterface

>>> src/tac_div.sv
// Restoring signed divider, one quotient bit per cycle, saturating quotient.
module tac_div #(
  parameter int NUM_W = 43,
  parameter int DEN_W = 27
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [NUM_W-1:0]         num,
  input  logic signed [DEN_W-1:0]         den,
  output logic                            done,
  output logic signed [tac_pkg::COEF_W-1:0] quo
);
  import tac_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] dmag_r, dmag_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic             neg_r, neg_nxt;

  logic [DEN_W+1:0] trial;
  logic [NUM_W-1:0] quo_twos;
  logic             ovf_pos, ovf_neg;

  assign trial = {1'b0, rem_r, quo_r[NUM_W-1]} - {2'b00, dmag_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dmag_nxt = dmag_r;
    quo_nxt  = quo_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      rem_nxt  = '0;
      dmag_nxt = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      quo_nxt  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      neg_nxt  = num[NUM_W-1] ^ den[DEN_W-1];
    end else if (busy_r) begin
      if (!trial[DEN_W+1]) begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DEN_W-2:0], quo_r[NUM_W-1]};
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    dmag_r <= dmag_nxt;
    quo_r  <= quo_nxt;
    neg_r  <= neg_nxt;
  end

  assign quo_twos = -quo_r;
  assign ovf_pos  = |quo_r[NUM_W-1:COEF_W-1];
  assign ovf_neg  = (|quo_r[NUM_W-1:COEF_W]) || (quo_r[COEF_W-1] && (|quo_r[COEF_W-2:0]));

  always_comb begin
    if (neg_r) begin
      quo = ovf_neg ? {1'b1, {(COEF_W-1){1'b0}}} : quo_twos[COEF_W-1:0];
    end else begin
      quo = ovf_pos ? {1'b0, {(COEF_W-1){1'b1}}} : quo_r[COEF_W-1:0];
    end
  end

  assign done = done_r;

endmodule

>>> src/touch_affine_calibration.sv
// Top level: three-point affine touch calibration with rotation fallback.
// Uncalibrated map item: result presented in the cycle after accept. Calibrated map item:
// computed through the shared multiply-accumulate unit. Solve item: runs the multiply-accumulate
// unit and the shared divider, which produces one quotient bit a cycle.
// One item at a time; the next item is taken once the result has been delivered.
// Synchronous reset restores register defaults, clears all six coefficients and the valid flag.
module touch_affine_calibration #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16,
  parameter int RAW_WIDTH  = 240,
  parameter int RAW_HEIGHT = 320
) (
  input  logic                             clk,
  input  logic                             rst_n,
  tac_in_if.sink                           in_ch,
  tac_out_if.source                        out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tac_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [tac_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [tac_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import tac_pkg::*;

  localparam int CW     = COORD_BITS;
  localparam int BW     = ((CW > RAW_W) ? CW : RAW_W) + 2;
  localparam int PW     = COEF_W + BW;
  localparam int ACC_W  = PW + 2;
  localparam int DW     = 2 * CW + 3;
  localparam int NUMW   = ((DW + FRAC_BITS) > 34) ? (DW + FRAC_BITS) : 34;
  localparam int FB_W   = RAW_W + 2;
  localparam logic signed [COEF_W-1:0] ONE_Q  = COEF_W'(1) << FRAC_BITS;
  localparam logic        [ACC_W-1:0]  HALF_Q = ACC_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ACC  = 5'b00100,
    S_DIV  = 5'b01000,
    S_POST = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    JOB_D,
    JOB_A,
    JOB_B,
    JOB_C,
    JOB_M
  } job_t;

  // configuration registers
  logic [REF_W-1:0]  ref_tl_r, ref_tr_r, ref_bl_r;
  logic [SIZE_W-1:0] width_r, height_r;
  logic [ROT_W-1:0]  rot_r;

  logic                 cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[CFG_ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_tl_r <= '0;
      ref_tr_r <= '0;
      ref_bl_r <= '0;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      rot_r    <= ROT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TOP_LEFT:      ref_tl_r <= pwdata[REF_W-1:0];
        REG_TOP_RIGHT:     ref_tr_r <= pwdata[REF_W-1:0];
        REG_BOTTOM_LEFT:   ref_bl_r <= pwdata[REF_W-1:0];
        REG_SCREEN_WIDTH:  width_r  <= pwdata[SIZE_W-1:0];
        REG_SCREEN_HEIGHT: height_r <= pwdata[SIZE_W-1:0];
        REG_FALLBACK_ROT:  rot_r    <= pwdata[ROT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TOP_LEFT:      prdata = CFG_DATA_W'(ref_tl_r);
      REG_TOP_RIGHT:     prdata = CFG_DATA_W'(ref_tr_r);
      REG_BOTTOM_LEFT:   prdata = CFG_DATA_W'(ref_bl_r);
      REG_SCREEN_WIDTH:  prdata = CFG_DATA_W'(width_r);
      REG_SCREEN_HEIGHT: prdata = CFG_DATA_W'(height_r);
      REG_FALLBACK_ROT:  prdata = CFG_DATA_W'(rot_r);
      default:           prdata = '0;
    endcase
  end

  function automatic logic [CW-1:0] ref_field(input logic [REF_W-1:0] r, input int k);
    logic [63:0] w;
    w = 64'(r) >> (k * CW);
    return w[CW-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] clamp_lim(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] m1;
    m1 = size - 1'b1;
    if (size == '0) begin
      return '0;
    end else if (m1[SIZE_W-1]) begin
      return {OUT_W{1'b1}};
    end else begin
      return m1[OUT_W-1:0];
    end
  endfunction

  function automatic logic [OUT_W-1:0] clamp_fb(input logic signed [FB_W-1:0] v,
                                                input logic [OUT_W-1:0] lim);
    if (v < 0) begin
      return '0;
    end else if (v > $signed({2'b00, lim})) begin
      return lim;
    end else begin
      return v[OUT_W-1:0];
    end
  endfunction

  // reference geometry
  logic [CW-1:0]        x0, y0, x1, y1, x2, y2, s0, s1, s2;
  logic signed [CW:0]   dx1, dy1, dx2, dy2, ds1, ds2;
  logic [OUT_W-1:0]     lim_x, lim_y, lim_axis;

  state_t                   state_r, state_nxt;
  job_t                     job_r, job_nxt;
  logic                     axis_r, axis_nxt;
  logic [1:0]               term_r, term_nxt;
  logic [RAW_W-1:0]         rx_r, rx_nxt, ry_r, ry_nxt;
  logic signed [PW-1:0]     prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [DW-1:0]     d_r, d_nxt;
  logic signed [COEF_W-1:0] coef_r [6];
  logic                     valid_r, valid_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]         out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                     out_cal_r, out_cal_nxt;

  logic                     coef_we, coef_clr;
  logic [2:0]               coef_widx;
  logic signed [COEF_W-1:0] coef_wdata;

  logic signed [COEF_W-1:0] op_a;
  logic signed [BW-1:0]     op_b;
  logic                     sub;
  logic [2:0]               coef_base, cidx;
  logic [1:0]               tsel;
  logic                     last_term;

  logic                     div_start, div_done;
  logic signed [NUMW-1:0]   div_num;
  logic signed [COEF_W-1:0] div_quo;

  logic [ACC_W-1:0]         rnd_u, rnd_q;
  logic [OUT_W-1:0]         map_val;
  logic                     c_ovf;
  logic signed [COEF_W-1:0] c_sat;

  logic                     in_acc;
  logic signed [FB_W-1:0]   rx_s, ry_s, px, py;

  assign x0 = ref_field(ref_tl_r, 0);
  assign y0 = ref_field(ref_tl_r, 1);
  assign x1 = ref_field(ref_tr_r, 0);
  assign y1 = ref_field(ref_tr_r, 1);
  assign x2 = ref_field(ref_bl_r, 0);
  assign y2 = ref_field(ref_bl_r, 1);
  assign s0 = axis_r ? ref_field(ref_tl_r, 3) : ref_field(ref_tl_r, 2);
  assign s1 = axis_r ? ref_field(ref_tr_r, 3) : ref_field(ref_tr_r, 2);
  assign s2 = axis_r ? ref_field(ref_bl_r, 3) : ref_field(ref_bl_r, 2);

  assign dx1 = $signed({1'b0, x1}) - $signed({1'b0, x0});
  assign dy1 = $signed({1'b0, y1}) - $signed({1'b0, y0});
  assign dx2 = $signed({1'b0, x2}) - $signed({1'b0, x0});
  assign dy2 = $signed({1'b0, y2}) - $signed({1'b0, y0});
  assign ds1 = $signed({1'b0, s1}) - $signed({1'b0, s0});
  assign ds2 = $signed({1'b0, s2}) - $signed({1'b0, s0});

  assign lim_x    = clamp_lim(width_r);
  assign lim_y    = clamp_lim(height_r);
  assign lim_axis = axis_r ? lim_y : lim_x;

  // operand selection for the shared multiplier
  assign coef_base = axis_r ? 3'd3 : 3'd0;
  assign tsel      = (job_r == JOB_C) ? ((term_r == 2'd2) ? 2'd1 : 2'd0) : term_r;
  assign cidx      = coef_base + {1'b0, tsel};
  assign last_term = (job_r == JOB_C || job_r == JOB_M) ? (term_r == 2'd2) : (term_r == 2'd1);

  always_comb begin
    op_a = '0;
    op_b = '0;
    sub  = 1'b0;
    unique case (job_r)
      JOB_D: begin
        if (term_r == 2'd0) begin
          op_a = COEF_W'(dx1);
          op_b = BW'(dy2);
        end else begin
          op_a = COEF_W'(dx2);
          op_b = BW'(dy1);
          sub  = 1'b1;
        end
      end
      JOB_A: begin
        if (term_r == 2'd0) begin
          op_a = COEF_W'(ds1);
          op_b = BW'(dy2);
        end else begin
          op_a = COEF_W'(ds2);
          op_b = BW'(dy1);
          sub  = 1'b1;
        end
      end
      JOB_B: begin
        if (term_r == 2'd0) begin
          op_a = COEF_W'(dx1);
          op_b = BW'(ds2);
        end else begin
          op_a = COEF_W'(dx2);
          op_b = BW'(ds1);
          sub  = 1'b1;
        end
      end
      JOB_C: begin
        case (term_r)
          2'd0: begin
            op_a = ONE_Q;
            op_b = $signed(BW'(s0));
          end
          2'd1: begin
            op_a = coef_r[cidx];
            op_b = $signed(BW'(x0));
            sub  = 1'b1;
          end
          default: begin
            op_a = coef_r[cidx];
            op_b = $signed(BW'(y0));
            sub  = 1'b1;
          end
        endcase
      end
      JOB_M: begin
        op_a = coef_r[cidx];
        case (term_r)
          2'd0:    op_b = $signed(BW'(rx_r));
          2'd1:    op_b = $signed(BW'(ry_r));
          default: op_b = BW'(1);
        endcase
      end
      default: ;
    endcase
  end

  assign prod_nxt = op_a * op_b;

  // rounding and clamping of a mapped axis
  assign rnd_u = $unsigned(acc_r) + HALF_Q;
  assign rnd_q = rnd_u >> FRAC_BITS;

  always_comb begin
    if (acc_r[ACC_W-1]) begin
      map_val = '0;
    end else if (rnd_q > ACC_W'(lim_axis)) begin
      map_val = lim_axis;
    end else begin
      map_val = rnd_q[OUT_W-1:0];
    end
  end

  assign c_ovf = ~((&acc_r[ACC_W-1:COEF_W-1]) | ~(|acc_r[ACC_W-1:COEF_W-1]));
  assign c_sat = c_ovf ? (acc_r[ACC_W-1] ? {1'b1, {(COEF_W-1){1'b0}}}
                                         : {1'b0, {(COEF_W-1){1'b1}}})
                       : acc_r[COEF_W-1:0];

  // rotation fallback
  assign rx_s = $signed({2'b00, in_ch.raw_x});
  assign ry_s = $signed({2'b00, in_ch.raw_y});

  always_comb begin
    case (rot_r)
      ROT_90: begin
        px = ry_s;
        py = FB_W'(RAW_WIDTH - 1) - rx_s;
      end
      ROT_180: begin
        px = FB_W'(RAW_WIDTH - 1) - rx_s;
        py = FB_W'(RAW_HEIGHT - 1) - ry_s;
      end
      ROT_270: begin
        px = FB_W'(RAW_HEIGHT - 1) - ry_s;
        py = rx_s;
      end
      default: begin
        px = rx_s;
        py = ry_s;
      end
    endcase
  end

  assign div_num   = NUMW'(acc_r) <<< FRAC_BITS;
  assign div_start = (state_r == S_POST) && (job_r == JOB_A || job_r == JOB_B);

  tac_div #(
    .NUM_W (NUMW),
    .DEN_W (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (d_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    axis_nxt      = axis_r;
    term_nxt      = term_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    acc_nxt       = acc_r;
    d_nxt         = d_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_cal_nxt   = out_cal_r;
    coef_we       = 1'b0;
    coef_clr      = 1'b0;
    coef_widx     = coef_base;
    coef_wdata    = c_sat;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rx_nxt   = in_ch.raw_x;
          ry_nxt   = in_ch.raw_y;
          axis_nxt = 1'b0;
          term_nxt = 2'd0;
          if (in_ch.func == FUNC_SOLVE) begin
            job_nxt   = JOB_D;
            state_nxt = S_MUL;
          end else if (valid_r) begin
            job_nxt   = JOB_M;
            state_nxt = S_MUL;
          end else begin
            out_x_nxt     = clamp_fb(px, lim_x);
            out_y_nxt     = clamp_fb(py, lim_y);
            out_cal_nxt   = 1'b0;
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_MUL: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (term_r == 2'd0) begin
          acc_nxt = sub ? -ACC_W'(prod_r) : ACC_W'(prod_r);
        end else begin
          acc_nxt = sub ? acc_r - ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
        end
        if (last_term) begin
          state_nxt = S_POST;
        end else begin
          term_nxt  = term_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_POST: begin
        term_nxt = 2'd0;
        unique case (job_r)
          JOB_D: begin
            if (acc_r == '0) begin
              coef_clr      = 1'b1;
              valid_nxt     = 1'b0;
              out_x_nxt     = '0;
              out_y_nxt     = '0;
              out_cal_nxt   = 1'b0;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              d_nxt     = DW'(acc_r);
              job_nxt   = JOB_A;
              state_nxt = S_MUL;
            end
          end
          JOB_A, JOB_B: begin
            state_nxt = S_DIV;
          end
          JOB_C: begin
            coef_we   = 1'b1;
            coef_widx = coef_base + 3'd2;
            if (!axis_r) begin
              axis_nxt  = 1'b1;
              job_nxt   = JOB_A;
              state_nxt = S_MUL;
            end else begin
              valid_nxt     = 1'b1;
              out_x_nxt     = '0;
              out_y_nxt     = '0;
              out_cal_nxt   = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          JOB_M: begin
            if (!axis_r) begin
              out_x_nxt = map_val;
              axis_nxt  = 1'b1;
              state_nxt = S_MUL;
            end else begin
              out_y_nxt     = map_val;
              out_cal_nxt   = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          coef_we    = 1'b1;
          coef_wdata = div_quo;
          term_nxt   = 2'd0;
          state_nxt  = S_MUL;
          if (job_r == JOB_A) begin
            coef_widx = coef_base;
            job_nxt   = JOB_B;
          end else begin
            coef_widx = coef_base + 3'd1;
            job_nxt   = JOB_C;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      job_r       <= JOB_D;
      axis_r      <= 1'b0;
      term_r      <= 2'd0;
      valid_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        coef_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      axis_r      <= axis_nxt;
      term_r      <= term_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (coef_clr) begin
        for (int i = 0; i < 6; i++) begin
          coef_r[i] <= '0;
        end
      end else if (coef_we) begin
        coef_r[coef_widx] <= coef_wdata;
      end
    end
    rx_r      <= rx_nxt;
    ry_r      <= ry_nxt;
    prod_r    <= prod_nxt;
    acc_r     <= acc_nxt;
    d_r       <= d_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_cal_r <= out_cal_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.screen_x   = out_x_r;
  assign out_ch.screen_y   = out_y_r;
  assign out_ch.calibrated = out_cal_r;

endmodule

>>> bench/tac_result_checker.sv
// Result checker: predicts every touch result from observed items and register writes.
module tac_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  tac_in_if                              in_ch,
  tac_out_if                             out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tac_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tac_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                           pready,
  output int                             mismatch_count,
  output int                             open_predictions
);
  import tac_pkg::*;

  localparam int     FRAC      = 16;
  localparam int     PANEL_W   = 240;
  localparam int     PANEL_H   = 320;
  localparam longint CLAMP_MAX = 4095;
  localparam longint Q_ONE     = longint'(1) <<< FRAC;
  localparam longint Q_MAX     = 64'sh7fff_ffff;
  localparam longint Q_MIN     = -64'sh8000_0000;

  typedef struct packed {
    logic [OUT_W-1:0] screen_x;
    logic [OUT_W-1:0] screen_y;
    logic             calibrated;
  } touch_result_t;

  touch_result_t     expected_points[$];
  logic [REF_W-1:0]  ref_pts [3];
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic [ROT_W-1:0]  rot_reg;
  int                coef [6];
  logic              cal_valid;
  int                result_index;

  function automatic longint ref_coord(int which, int k);
    longint v;
    v = 0;
    v[RAW_W-1:0] = ref_pts[which][k*RAW_W +: RAW_W];
    return v;
  endfunction

  function automatic int saturate32(longint v);
    if (v > Q_MAX) return int'(Q_MAX);
    if (v < Q_MIN) return int'(Q_MIN);
    return int'(v);
  endfunction

  function automatic logic [OUT_W-1:0] clamp_axis(longint v, logic [SIZE_W-1:0] size);
    longint lim;
    lim = (size == 0) ? 0 : longint'(size) - 1;
    if (lim > CLAMP_MAX) lim = CLAMP_MAX;
    if (v < 0) return '0;
    if (v > lim) return lim[OUT_W-1:0];
    return v[OUT_W-1:0];
  endfunction

  function automatic longint round_q(longint v);
    longint half;
    half = longint'(1) <<< (FRAC - 1);
    if (v >= 0) return (v + half) >>> FRAC;
    return -((-v + half) >>> FRAC);
  endfunction

  function automatic void fit_axis(input longint d, dx1, dy1, dx2, dy2, x0, y0, s0, s1, s2,
                                   input int base);
    longint na;
    longint nb;
    int     a;
    int     b;
    na = (s1 - s0) * dy2 - (s2 - s0) * dy1;
    nb = dx1 * (s2 - s0) - dx2 * (s1 - s0);
    a = saturate32((na * Q_ONE) / d);
    b = saturate32((nb * Q_ONE) / d);
    coef[base]     = a;
    coef[base + 1] = b;
    coef[base + 2] = saturate32(s0 * Q_ONE - longint'(a) * x0 - longint'(b) * y0);
  endfunction

  function automatic touch_result_t predict_response(logic [FUNC_W-1:0] f,
                                                     logic [RAW_W-1:0] rx_in,
                                                     logic [RAW_W-1:0] ry_in);
    touch_result_t r;
    longint x0, y0, dx1, dy1, dx2, dy2, d;
    longint rx, ry, vx, vy, px, py;
    r = '0;
    rx = longint'(rx_in);
    ry = longint'(ry_in);
    if (f == FUNC_SOLVE) begin
      x0  = ref_coord(0, 0);
      y0  = ref_coord(0, 1);
      dx1 = ref_coord(1, 0) - x0;
      dy1 = ref_coord(1, 1) - y0;
      dx2 = ref_coord(2, 0) - x0;
      dy2 = ref_coord(2, 1) - y0;
      d   = dx1 * dy2 - dx2 * dy1;
      if (d == 0) begin
        for (int i = 0; i < 6; i++) coef[i] = 0;
        cal_valid = 1'b0;
      end else begin
        fit_axis(d, dx1, dy1, dx2, dy2, x0, y0,
                 ref_coord(0, 2), ref_coord(1, 2), ref_coord(2, 2), 0);
        fit_axis(d, dx1, dy1, dx2, dy2, x0, y0,
                 ref_coord(0, 3), ref_coord(1, 3), ref_coord(2, 3), 3);
        cal_valid = 1'b1;
        r.calibrated = 1'b1;
      end
    end else if (cal_valid) begin
      vx = longint'(coef[0]) * rx + longint'(coef[1]) * ry + longint'(coef[2]);
      vy = longint'(coef[3]) * rx + longint'(coef[4]) * ry + longint'(coef[5]);
      r.screen_x   = clamp_axis(round_q(vx), width_reg);
      r.screen_y   = clamp_axis(round_q(vy), height_reg);
      r.calibrated = 1'b1;
    end else begin
      case (rot_reg)
        ROT_90: begin
          px = ry;
          py = PANEL_W - 1 - rx;
        end
        ROT_180: begin
          px = PANEL_W - 1 - rx;
          py = PANEL_H - 1 - ry;
        end
        ROT_270: begin
          px = PANEL_H - 1 - ry;
          py = rx;
        end
        default: begin
          px = rx;
          py = ry;
        end
      endcase
      r.screen_x = clamp_axis(px, width_reg);
      r.screen_y = clamp_axis(py, height_reg);
    end
    return r;
  endfunction

  task automatic compare_field(string field, int want, int got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("result %0d: %s expected %0d, got %0d", result_index, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    touch_result_t seen;
    touch_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) ref_pts[i] = '0;
      for (int i = 0; i < 6; i++) coef[i] = 0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      rot_reg    = ROT_RESET;
      cal_valid  = 1'b0;
      expected_points.delete();
      mismatch_count = 0;
      result_index   = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:3])
          REG_TOP_LEFT:      ref_pts[0] = pwdata[REF_W-1:0];
          REG_TOP_RIGHT:     ref_pts[1] = pwdata[REF_W-1:0];
          REG_BOTTOM_LEFT:   ref_pts[2] = pwdata[REF_W-1:0];
          REG_SCREEN_WIDTH:  width_reg  = pwdata[SIZE_W-1:0];
          REG_SCREEN_HEIGHT: height_reg = pwdata[SIZE_W-1:0];
          REG_FALLBACK_ROT:  rot_reg    = pwdata[ROT_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_points.push_back(predict_response(in_ch.func, in_ch.raw_x, in_ch.raw_y));
      if (out_ch.valid && out_ch.ready) begin
        seen = {out_ch.screen_x, out_ch.screen_y, out_ch.calibrated};
        if (expected_points.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: nothing pending, got x=%0d y=%0d calibrated=%0d",
                     result_index, seen.screen_x, seen.screen_y, seen.calibrated);
        end else begin
          want = expected_points.pop_front();
          compare_field("screen_x", want.screen_x, seen.screen_x);
          compare_field("screen_y", want.screen_y, seen.screen_y);
          compare_field("calibrated", want.calibrated, seen.calibrated);
        end
        result_index++;
      end
    end
    open_predictions = expected_points.size();
  end

endmodule

>>> bench/touch_affine_calibration_tb.sv
// Testbench top: drives touch items and register writes, collects results, gives the verdict.
module touch_affine_calibration_tb;
  import tac_pkg::*;

  localparam int ITEM_TARGET  = 1750;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 300;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic                  pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;

  int send_max;
  int recv_max;
  int sent;
  int returned;
  int solves;
  int rounds;
  int idle_cycles;
  int mismatch_count;
  int open_predictions;

  tac_in_if  in_ch ();
  tac_out_if out_ch ();

  touch_affine_calibration dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tac_result_checker result_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ch            (in_ch),
    .out_ch           (out_ch),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatch_count   (mismatch_count),
    .open_predictions (open_predictions)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [REF_W-1:0] pack_ref(int rx, int ry, int sx, int sy);
    return {sy[RAW_W-1:0], sx[RAW_W-1:0], ry[RAW_W-1:0], rx[RAW_W-1:0]};
  endfunction

  function automatic int draw_gap_limit();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 3;
      default: return 16;
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] draw_size();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return SIZE_W'(1);
      2:       return SIZE_W'(4096);
      3:       return SIZE_W'($urandom_range(4097, 8191));
      default: return SIZE_W'($urandom_range(64, 1280));
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return RAW_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic int raw_near(int lo, int hi, logic flip);
    int v;
    v = $urandom_range(lo, hi);
    return flip ? 4095 - v : v;
  endfunction

  task automatic push_item(logic [FUNC_W-1:0] f, logic [RAW_W-1:0] x, logic [RAW_W-1:0] y);
    int gap;
    gap = (send_max == 0) ? 0 : $urandom_range(0, send_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.raw_x <= x;
    in_ch.raw_y <= y;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    if (f == FUNC_SOLVE) solves++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic program_regs(input logic [REF_W-1:0] tl, tr, bl,
                              input logic [SIZE_W-1:0] w, h,
                              input logic [ROT_W-1:0] rot);
    in_ch.valid <= 1'b0;
    while (returned != sent) @(posedge clk);
    write_reg(REG_TOP_LEFT, CFG_DATA_W'(tl));
    write_reg(REG_TOP_RIGHT, CFG_DATA_W'(tr));
    write_reg(REG_BOTTOM_LEFT, CFG_DATA_W'(bl));
    write_reg(REG_SCREEN_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_FALLBACK_ROT, CFG_DATA_W'(rot));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    rounds++;
  endtask

  task automatic random_setup();
    logic [REF_W-1:0]  refs [3];
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    int   sw, sh, kind, x0, y0, k;
    logic flip_x, flip_y;
    w  = draw_size();
    h  = draw_size();
    sw = (w == 0) ? 1 : ((w > 4096) ? 4096 : int'(w));
    sh = (h == 0) ? 1 : ((h > 4096) ? 4096 : int'(h));
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      flip_x  = 1'($urandom_range(0, 1));
      flip_y  = 1'($urandom_range(0, 1));
      refs[0] = pack_ref(raw_near(0, 900, flip_x), raw_near(0, 900, flip_y),
                         $urandom_range(0, sw / 8), $urandom_range(0, sh / 8));
      refs[1] = pack_ref(raw_near(3000, 4095, flip_x), raw_near(0, 900, flip_y),
                         sw - 1 - $urandom_range(0, sw / 8), $urandom_range(0, sh / 8));
      refs[2] = pack_ref(raw_near(0, 900, flip_x), raw_near(3000, 4095, flip_y),
                         $urandom_range(0, sw / 8), sh - 1 - $urandom_range(0, sh / 8));
    end else if (kind < 8) begin
      x0 = $urandom_range(0, 1300);
      y0 = $urandom_range(0, 1300);
      k  = $urandom_range(0, 1300);
      if ($urandom_range(0, 1)) begin
        refs[0] = pack_ref(x0, y0, $urandom_range(0, 4095), $urandom_range(0, 4095));
        refs[1] = pack_ref(x0 + k, y0 + k, $urandom_range(0, 4095), $urandom_range(0, 4095));
        refs[2] = pack_ref(x0 + 2 * k, y0 + 2 * k, $urandom_range(0, 4095),
                           $urandom_range(0, 4095));
      end else begin
        refs[0] = pack_ref(x0, y0, $urandom_range(0, 4095), $urandom_range(0, 4095));
        refs[1] = pack_ref(x0, y0 + k, $urandom_range(0, 4095), $urandom_range(0, 4095));
        refs[2] = pack_ref(x0, y0 + 2 * k, $urandom_range(0, 4095), $urandom_range(0, 4095));
      end
    end else begin
      for (int i = 0; i < 3; i++) refs[i] = REF_W'({$urandom, $urandom});
    end
    program_regs(refs[0], refs[1], refs[2], w, h, ROT_W'($urandom_range(0, 3)));
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no progress for %0d cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = (recv_max == 0) ? 0 : $urandom_range(0, recv_max);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      returned++;
    end
  end

  initial begin
    int               n;
    logic             solve_first;
    logic [FUNC_W-1:0] f;
    rst_n        <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.func   <= FUNC_MAP;
    in_ch.raw_x  <= '0;
    in_ch.raw_y  <= '0;
    out_ch.ready <= 1'b0;
    send_max = 0;
    recv_max = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: rotation fallback, then a fit on all-zero references
    push_item(FUNC_MAP, 12'd0, 12'd0);
    push_item(FUNC_MAP, 12'hfff, 12'hfff);
    push_item(FUNC_MAP, 12'd239, 12'd319);
    push_item(FUNC_MAP, 12'd0, 12'hfff);
    push_item(FUNC_MAP, 12'hfff, 12'd0);
    push_item(FUNC_SOLVE, 12'hfff, 12'hfff);

    program_regs(pack_ref(200, 300, 20, 20), pack_ref(3900, 320, 300, 25),
                 pack_ref(220, 3800, 22, 220), 13'd320, 13'd240, ROT_0);
    push_item(FUNC_SOLVE, 12'd0, 12'd0);
    push_item(FUNC_MAP, 12'd0, 12'd0);
    push_item(FUNC_MAP, 12'hfff, 12'hfff);
    push_item(FUNC_MAP, 12'd2048, 12'd2048);
    push_item(FUNC_MAP, 12'hfff, 12'd0);
    push_item(FUNC_MAP, 12'd0, 12'hfff);

    // unit determinant: saturated coefficients, zero width, oversized height
    program_regs(pack_ref(2000, 2000, 0, 4095), pack_ref(4095, 2001, 0, 0),
                 pack_ref(4094, 2001, 4095, 0), 13'd0, 13'h1fff, ROT_90);
    push_item(FUNC_SOLVE, 12'd0, 12'd0);
    push_item(FUNC_MAP, 12'd2000, 12'd2000);
    push_item(FUNC_MAP, 12'hfff, 12'hfff);
    push_item(FUNC_MAP, 12'd0, 12'd0);

    // collinear references drop back to rotation
    program_regs(pack_ref(100, 100, 10, 10), pack_ref(200, 200, 50, 60),
                 pack_ref(300, 300, 90, 100), 13'd4096, 13'd1, ROT_180);
    push_item(FUNC_SOLVE, 12'd0, 12'd0);
    push_item(FUNC_MAP, 12'd0, 12'd0);
    push_item(FUNC_MAP, 12'hfff, 12'hfff);
    push_item(FUNC_MAP, 12'd239, 12'd319);
    push_item(FUNC_MAP, 12'd100, 12'd50);

    while (sent < ITEM_TARGET) begin
      random_setup();
      send_max    = draw_gap_limit();
      recv_max    = draw_gap_limit();
      n           = $urandom_range(8, 40);
      solve_first = ($urandom_range(0, 4) != 0);
      for (int i = 0; i < n; i++) begin
        f = ((i == 0 && solve_first) || $urandom_range(0, 29) == 0) ? FUNC_SOLVE : FUNC_MAP;
        push_item(f, pick_coord(), pick_coord());
      end
    end

    in_ch.valid <= 1'b0;
    while (returned != sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d items (%0d solves) across %0d register setups, %0d results seen",
             sent, solves, rounds, returned);
    if (open_predictions != 0)
      $display("%0d predicted results never arrived", open_predictions);
    if (mismatch_count == 0 && open_predictions == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> touch_affine_calibration.f
src/tac_pkg.sv
src/tac_if.sv
src/tac_div.sv
src/touch_affine_calibration.sv
bench/tac_result_checker.sv
bench/touch_affine_calibration_tb.sv
